@@ hdl/wsfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_pkg: shared types and constants of the WebSocket frame encoder
// Holds the queue entry layout, the configuration set, the register indexes
// and the header encoding constants.
// ----------------------------------------------------------------------------
package wsfe_pkg;

   localparam int WSFE_QUEUE_DEPTH = 4;
   localparam int LEN_W            = 63;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_FRAME   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_BITS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_OPCODE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ENABLE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_KEY      = 3'd4;

   // Input item kinds.
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   // Length encoding limits and codes.
   localparam logic [15:0] SHORT_LEN_MAX = 16'd125;
   localparam logic [6:0]  LEN_CODE_16   = 7'd126;
   localparam logic [6:0]  LEN_CODE_64   = 7'd127;

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_MID,
      LEN_LONG
   } len_class_type;

   typedef struct packed {
      logic        final_frame;
      logic [2:0]  reserved_bits;
      logic [3:0]  frame_opcode;
      logic        mask_enable;
      logic [31:0] mask_key;
   } cfg_type;

   // One queued unit of work: a frame header or one payload byte.
   typedef struct packed {
      logic             is_hdr;
      len_class_type    len_class;
      logic [LEN_W-1:0] data;
      logic [1:0]       phase;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Key byte for a phase, most significant byte first.
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

@@ hdl/wsfe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_front: input classification
// Accepts request beats, tracks the open frame and queues header or payload
// work for the back end.
// ----------------------------------------------------------------------------
module wsfe_front
   import wsfe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             func,
   input  wire logic [LEN_W-1:0] frame_length,
   input  wire logic [7:0]       payload_byte,
   output push_type              push
);

   logic             frame_open_ff, frame_open_in;
   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [1:0]       key_phase_ff, key_phase_in;
   logic [LEN_W-1:0] left_dec;
   len_class_type    len_class;

   assign left_dec = bytes_left_ff - LEN_W'(1);

   // Length class of a new frame.
   always_comb begin
      if (|frame_length[LEN_W-1:16]) begin
         len_class = LEN_LONG;
      end else if (frame_length[15:0] > SHORT_LEN_MAX) begin
         len_class = LEN_MID;
      end else begin
         len_class = LEN_SHORT;
      end
   end

   // Frame tracking and queue entry formation.
   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      key_phase_in  = key_phase_ff;
      push.push            = 1'b0;
      push.entry.is_hdr    = 1'b1;
      push.entry.len_class = len_class;
      push.entry.data      = frame_length;
      push.entry.phase     = key_phase_ff;
      push.entry.last      = (frame_length == '0);
      if (accept) begin
         if (func == FUNC_START) begin
            // A start abandons any open frame.
            push.push     = 1'b1;
            bytes_left_in = frame_length;
            key_phase_in  = 2'd0;
            frame_open_in = (frame_length != '0);
         end else if (frame_open_ff) begin
            push.push         = 1'b1;
            push.entry.is_hdr = 1'b0;
            push.entry.data   = {{(LEN_W-8){1'b0}}, payload_byte};
            push.entry.last   = (left_dec == '0);
            bytes_left_in     = left_dec;
            key_phase_in      = key_phase_ff + 2'd1;
            frame_open_in     = (left_dec != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
         key_phase_ff  <= 2'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         key_phase_ff  <= key_phase_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/wsfe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_queue: work queue between front and back end
// A small register FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module wsfe_queue
   import wsfe_pkg::*;
#(
   parameter int DEPTH = WSFE_QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output entry_type     head,
   output logic          not_empty,
   output logic          full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push.push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule
`default_nettype wire

@@ hdl/wsfe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_back: byte sequencer
// Expands a header entry into its bytes one per cycle while the output is not
// stalled, masks payload bytes and holds the result in an output register.
// ----------------------------------------------------------------------------
module wsfe_back
   import wsfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire entry_type  head,
   input  wire logic       head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_end
);

   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_frame_end_ff;
   logic       out_free, produce, last_step;
   logic [7:0] next_byte;
   logic [3:0] ext_n, key_n, last_idx;
   logic [6:0] len_code;
   logic [2:0] len_idx;
   logic [1:0] key_idx;

   // Length byte, index 0 is least significant.
   function automatic logic [7:0] len_byte(input logic [LEN_W-1:0] len,
                                           input logic [2:0] idx);
      logic [63:0] wide;
      wide = {1'b0, len};
      return wide[{idx, 3'b000} +: 8];
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign produce  = head_valid && out_free;
   assign pop      = produce && last_step;

   // Header layout for this entry.
   always_comb begin
      unique case (head.len_class)
         LEN_SHORT: begin
            ext_n    = 4'd0;
            len_code = head.data[6:0];
         end
         LEN_MID: begin
            ext_n    = 4'd2;
            len_code = LEN_CODE_16;
         end
         LEN_LONG: begin
            ext_n    = 4'd8;
            len_code = LEN_CODE_64;
         end
         default: begin
            ext_n    = 4'd0;
            len_code = head.data[6:0];
         end
      endcase
      key_n    = cfg.mask_enable ? 4'd4 : 4'd0;
      last_idx = 4'd1 + ext_n + key_n;
      len_idx  = 3'(ext_n + 4'd1 - step_ff);
      key_idx  = 2'(step_ff - 4'd2 - ext_n);
   end

   // Byte selection for the current step.
   always_comb begin
      if (!head.is_hdr) begin
         next_byte = head.data[7:0]
                   ^ (cfg.mask_enable ? key_byte(cfg.mask_key, head.phase) : 8'h00);
         last_step = 1'b1;
      end else begin
         last_step = (step_ff == last_idx);
         if (step_ff == 4'd0) begin
            next_byte = {cfg.final_frame, cfg.reserved_bits, cfg.frame_opcode};
         end else if (step_ff == 4'd1) begin
            next_byte = {cfg.mask_enable, len_code};
         end else if (step_ff < ext_n + 4'd2) begin
            next_byte = len_byte(head.data, len_idx);
         end else begin
            next_byte = key_byte(cfg.mask_key, key_idx);
         end
      end
   end

   // Step counter and output valid.
   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (produce) begin
         rsp_valid_in = 1'b1;
         step_in      = last_step ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_out_byte_ff  <= next_byte;
         rsp_frame_end_ff <= last_step && head.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule
`default_nettype wire

@@ hdl/websocket_frame_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_encoder: WebSocket base framing encoder
// Front end, work queue and byte sequencer with the configuration registers.
// ----------------------------------------------------------------------------
// A start beat (req_func = 0) with the payload length produces the frame
// header, 2 to 14 response beats (first byte, length code, 0, 2 or 8
// extended length bytes, and 4 key bytes when masking is on); each payload
// beat (req_func = 1) inside an open frame produces one, possibly masked,
// byte. Request beats are taken one per cycle while the work queue has room;
// the byte sequencer sends one beat per cycle unless rsp_stall holds it, so
// payload streams at one byte per cycle and a header occupies it until all
// its bytes are out. Payload beats outside a frame are dropped. Configuration
// must be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module websocket_frame_encoder
   import wsfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = WSFE_QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_func,
   input  wire logic [LEN_W-1:0]       req_frame_length,
   input  wire logic [7:0]             req_payload_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_frame_end,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff;
   push_type  push;
   entry_type head;
   logic      head_valid, queue_full, pop, req_accept;

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.final_frame   <= 1'b1;
         cfg_ff.reserved_bits <= 3'd0;
         cfg_ff.frame_opcode  <= 4'd1;
         cfg_ff.mask_enable   <= 1'b0;
         cfg_ff.mask_key      <= 32'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FINAL_FRAME:   cfg_ff.final_frame   <= csr_wdata[0];
            CSR_RESERVED_BITS: cfg_ff.reserved_bits <= csr_wdata[2:0];
            CSR_FRAME_OPCODE:  cfg_ff.frame_opcode  <= csr_wdata[3:0];
            CSR_MASK_ENABLE:   cfg_ff.mask_enable   <= csr_wdata[0];
            CSR_MASK_KEY:      cfg_ff.mask_key      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wsfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .func         (req_func),
      .frame_length (req_frame_length),
      .payload_byte (req_payload_byte),
      .push         (push)
   );

   wsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   wsfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

@@ hdl/wsfe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_checker: port level checks of the frame encoder
// Watches the response channel and reset behavior at the top level ports.
// ----------------------------------------------------------------------------
module wsfe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_frame_end
);

   // Reset leaves no response pending and the queue open for requests.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response pending or request stalled after reset");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_frame_end))
      else $error("stalled response beat changed");

   // A response cannot appear in the cycle right after reset.
   a_no_rsp_from_reset: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("response raised straight out of reset");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_frame_end (rsp_frame_end)
);
`default_nettype wire
